// ===== src/rhsm_pkg.sv =====
package rhsm_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_PAT   = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] CFG_RADIX  = 2'd0;
  localparam logic [1:0] CFG_MOD    = 2'd1;
  localparam logic [1:0] CFG_PATLEN = 2'd2;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_SUM   = 1'b1;

  localparam int RADIX_W  = 10;
  localparam int PATLEN_W = 5;
  localparam int CNT_W    = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RED,
    ST_T_CVD,
    ST_T_DROP,
    ST_T_MUL,
    ST_T_CV,
    ST_T_PH,
    ST_T_CMP,
    ST_T_END,
    ST_P_RR,
    ST_P_PH,
    ST_P_CV,
    ST_P_LEAD,
    ST_OUT_M,
    ST_OUT_S
  } st_t;

  typedef struct packed {
    logic       alnum;
    logic [5:0] val;
  } cmap_t;

  function automatic cmap_t char_map(input logic [7:0] c);
    cmap_t r;
    r.alnum = 1'b1;
    r.val   = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41) + 6'd10;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61) + 6'd36;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30);
    end else begin
      r.alnum = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== src/rhsm_modmul.sv =====
// Bit-serial (a * b) mod q, b taken MSB first, one bit per cycle. a must be below q.
module rhsm_modmul #(
  parameter int MW  = 31,
  parameter int OPW = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [MW-1:0]  a,
  input  logic [OPW-1:0] b,
  input  logic [MW-1:0]  q,
  output logic           done,
  output logic [MW-1:0]  res
);

  localparam int CW = $clog2(OPW + 1);

  logic [MW-1:0]  r_r, a_r, q_r;
  logic [OPW-1:0] b_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [MW+1:0]  s, q1, q2;
  logic [MW-1:0]  r_nxt;

  always_comb begin
    q1 = {2'b00, q_r};
    q2 = {1'b0, q_r, 1'b0};
    s  = {1'b0, r_r, 1'b0} + (b_r[OPW-1] ? {2'b00, a_r} : '0);
    if (s >= q2) begin
      r_nxt = MW'(s - q2);
    end else if (s >= q1) begin
      r_nxt = MW'(s - q1);
    end else begin
      r_nxt = MW'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(OPW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= '0;
      a_r <= a;
      b_r <= b;
      q_r <= q;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[OPW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

// ===== src/rolling_hash_string_matcher_unit.sv =====
// Rabin-Karp string matcher.
// Input stream: in_tuser = request (clear, pattern char, text char), in_tdata = char byte,
// in_tlast = end of text (text chars only). One transaction at a time; in_tready is low
// while an item is in work or its results wait.
// Output stream: out_tuser = kind (match / end-of-text summary), out_tdata = match
// position (low 32) and spurious count (high 32), out_tlast on the last result of an item.
// Config channel cfg_valid/cfg_index/cfg_data writes radix, modulus, pattern length;
// cfg_ready is always high. Write only while the block is idle.
// Products: every modular product runs on one shared bit-serial unit of OPW bits
// (OPW = max(MOD_WIDTH,10)). A pattern char takes 3-4 passes, a text char 3-6 passes
// plus up to m compare steps. Results then wait in the output register until taken;
// a receiver stall simply holds the block.
// Reset: synchronous, clears hashes, counters, window and registers to defaults.
module rolling_hash_string_matcher_unit
  import rhsm_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int MOD_WIDTH   = 31,
  parameter int POS_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] ch
  input  logic [1:0]           in_tuser,   // [1:0] req_type
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [31:0] match_pos, [63:32] spurious_count
  output logic                 out_tuser,  // [0] kind
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [((MOD_WIDTH > RADIX_W) ? MOD_WIDTH : RADIX_W)-1:0] cfg_data
);

  localparam int MW  = MOD_WIDTH;
  localparam int OPW = (MOD_WIDTH > RADIX_W) ? MOD_WIDTH : RADIX_W;
  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  st_t state_r, state_nxt;
  logic launch_r;

  logic [RADIX_W-1:0]  radix_r;
  logic [MW-1:0]       mod_r;
  logic [PATLEN_W-1:0] plen_r;

  logic [7:0]          pstore_r [MAX_PATTERN];
  logic [7:0]          wstore_r [MAX_PATTERN];
  logic [MW-1:0]       ph_r, wh_r, lead_r, tmp_r, tmp2_r;
  logic [LW-1:0]       loaded_r;
  logic [POS_WIDTH-1:0] text_r;
  logic [CNT_W-1:0]    fh_r, sum_r, mpos_r;
  logic [1:0]          req_r;
  logic [7:0]          ch_r;
  logic                eot_r, have_m_r;
  logic [IW-1:0]       idx_r;

  logic [MW-1:0]  q, one_q, u_a, u_res;
  logic [OPW-1:0] u_b, cvb;
  logic           u_start, u_done, pass_st;
  logic [LW-1:0]  m;
  logic [IW-1:0]  rd_idx;
  logic [7:0]     sel_ch;
  cmap_t          cm;
  logic [POS_WIDTH-1:0] text_inc;
  logic [MW:0]    add_s, sub_s;
  logic           in_acc, out_acc, cmp_eq, cmp_last;

  assign q     = (mod_r == '0) ? MW'(1) : mod_r;
  assign one_q = (q == MW'(1)) ? '0 : MW'(1);
  assign m = (plen_r == '0) ? LW'(1) :
             (32'(plen_r) > 32'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(plen_r);

  assign rd_idx = IW'(LW'(MAX_PATTERN) - m) + idx_r;
  assign sel_ch = (state_r == ST_T_CVD) ? wstore_r[rd_idx] : ch_r;
  assign cm     = char_map(sel_ch);
  assign cvb    = cm.alnum ? OPW'(cm.val) : OPW'(q - MW'(1));

  assign text_inc = (text_r == '1) ? text_r : text_r + POS_WIDTH'(1);
  assign add_s    = {1'b0, tmp_r} + {1'b0, u_res};
  assign sub_s    = (tmp_r >= u_res) ? {1'b0, tmp_r} - {1'b0, u_res}
                                     : {1'b0, tmp_r} + {1'b0, q} - {1'b0, u_res};
  assign cmp_eq   = pstore_r[idx_r] == wstore_r[rd_idx];
  assign cmp_last = LW'(idx_r) == (m - LW'(1));

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  rhsm_modmul #(.MW(MW), .OPW(OPW)) u_mm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .a     (u_a),
    .b     (u_b),
    .q     (q),
    .done  (u_done),
    .res   (u_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_TEXT) begin
            state_nxt = ST_T_RED;
          end else if (in_tuser == REQ_PAT && loaded_r < m) begin
            state_nxt = ST_P_RR;
          end
        end
      end
      ST_T_RED:  if (u_done) state_nxt = (text_r >= POS_WIDTH'(m)) ? ST_T_CVD : ST_T_MUL;
      ST_T_CVD:  if (u_done) state_nxt = ST_T_DROP;
      ST_T_DROP: if (u_done) state_nxt = ST_T_MUL;
      ST_T_MUL:  if (u_done) state_nxt = ST_T_CV;
      ST_T_CV: begin
        if (u_done) begin
          state_nxt = (text_inc >= POS_WIDTH'(m) && loaded_r == m) ? ST_T_PH : ST_T_END;
        end
      end
      ST_T_PH:   if (u_done) state_nxt = (u_res == wh_r) ? ST_T_CMP : ST_T_END;
      ST_T_CMP:  if (!cmp_eq || cmp_last) state_nxt = ST_T_END;
      ST_T_END: begin
        if (have_m_r) state_nxt = ST_OUT_M;
        else if (eot_r) state_nxt = ST_OUT_S;
        else state_nxt = ST_IDLE;
      end
      ST_P_RR:   if (u_done) state_nxt = ST_P_PH;
      ST_P_PH:   if (u_done) state_nxt = ST_P_CV;
      ST_P_CV:   if (u_done) state_nxt = (loaded_r != '0) ? ST_P_LEAD : ST_IDLE;
      ST_P_LEAD: if (u_done) state_nxt = ST_IDLE;
      ST_OUT_M:  if (out_acc) state_nxt = eot_r ? ST_OUT_S : ST_IDLE;
      ST_OUT_S:  if (out_acc) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and shared-unit operands
  always_comb begin
    in_tready = state_r == ST_IDLE;
    out_tvalid = (state_r == ST_OUT_M) || (state_r == ST_OUT_S);
    out_tuser  = (state_r == ST_OUT_S) ? KIND_SUM : KIND_MATCH;
    out_tlast  = (state_r == ST_OUT_S) || !eot_r;
    out_tdata  = (state_r == ST_OUT_S) ? {sum_r, 32'd0} : {32'd0, mpos_r};
    pass_st    = 1'b1;
    u_a        = one_q;
    u_b        = cvb;
    case (state_r)
      ST_T_RED:  u_b = OPW'(wh_r);
      ST_T_CVD:  u_b = cvb;
      ST_T_DROP: begin u_a = tmp2_r; u_b = OPW'(lead_r); end
      ST_T_MUL:  begin u_a = tmp_r;  u_b = OPW'(radix_r); end
      ST_T_CV:   u_b = cvb;
      ST_T_PH:   u_b = OPW'(ph_r);
      ST_P_RR:   u_b = OPW'(radix_r);
      ST_P_PH:   begin u_a = tmp2_r; u_b = OPW'(ph_r); end
      ST_P_CV:   u_b = cvb;
      ST_P_LEAD: begin u_a = tmp2_r; u_b = OPW'(lead_r); end
      default:   pass_st = 1'b0;
    endcase
    u_start = pass_st && launch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= state_nxt != state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(62);
      mod_r   <= MW'(101);
      plen_r  <= PATLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIX:  radix_r <= cfg_data[RADIX_W-1:0];
        CFG_MOD:    mod_r   <= cfg_data[MW-1:0];
        CFG_PATLEN: plen_r  <= cfg_data[PATLEN_W-1:0];
        default:    ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= '0;
      wh_r     <= '0;
      lead_r   <= MW'(1);
      loaded_r <= '0;
      text_r   <= '0;
      fh_r     <= '0;
      have_m_r <= 1'b0;
      eot_r    <= 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) wstore_r[i] <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r    <= in_tuser;
            ch_r     <= in_tdata;
            eot_r    <= in_tlast && (in_tuser == REQ_TEXT);
            idx_r    <= '0;
            have_m_r <= 1'b0;
            if (in_tuser == REQ_CLEAR) begin
              ph_r     <= '0;
              wh_r     <= '0;
              lead_r   <= MW'(1);
              loaded_r <= '0;
              text_r   <= '0;
              fh_r     <= '0;
              for (int i = 0; i < MAX_PATTERN; i++) wstore_r[i] <= '0;
            end
          end
        end
        ST_T_RED:  if (u_done) tmp_r <= u_res;
        ST_T_CVD:  if (u_done) tmp2_r <= u_res;
        ST_T_DROP: if (u_done) tmp_r <= MW'((sub_s >= {1'b0, q}) ? sub_s - {1'b0, q} : sub_s);
        ST_T_MUL:  if (u_done) tmp_r <= u_res;
        ST_T_CV: begin
          if (u_done) begin
            wh_r   <= MW'((add_s >= {1'b0, q}) ? add_s - {1'b0, q} : add_s);
            text_r <= text_inc;
            for (int i = 0; i < MAX_PATTERN - 1; i++) wstore_r[i] <= wstore_r[i+1];
            wstore_r[MAX_PATTERN-1] <= ch_r;
          end
        end
        ST_T_CMP: begin
          idx_r <= idx_r + IW'(1);
          if (!cmp_eq) begin
            if (fh_r != '1) fh_r <= fh_r + CNT_W'(1);
          end else if (cmp_last) begin
            have_m_r <= 1'b1;
            mpos_r   <= CNT_W'(text_r - POS_WIDTH'(m));
          end
        end
        ST_T_END: begin
          if (eot_r) begin
            sum_r  <= fh_r;
            wh_r   <= '0;
            text_r <= '0;
            fh_r   <= '0;
            for (int i = 0; i < MAX_PATTERN; i++) wstore_r[i] <= '0;
          end
        end
        ST_P_RR:   if (u_done) tmp2_r <= u_res;
        ST_P_PH:   if (u_done) tmp_r <= u_res;
        ST_P_CV: begin
          if (u_done) begin
            ph_r     <= MW'((add_s >= {1'b0, q}) ? add_s - {1'b0, q} : add_s);
            loaded_r <= loaded_r + LW'(1);
          end
        end
        ST_P_LEAD: if (u_done) lead_r <= u_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_P_CV && u_done) pstore_r[loaded_r[IW-1:0]] <= ch_r;
  end

  // req_r kept for debug visibility of the item in work
  logic req_text_w;
  assign req_text_w = req_r == REQ_TEXT;

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input ready while a result is pending");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SUM) |-> out_tlast)
    else $error("summary must close the run");

  a_cmp_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_CMP) |-> (loaded_r == m && req_text_w))
    else $error("compare with incomplete pattern");

  a_done_pass: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> pass_st) else $error("product finished outside a pass state");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rhsm_pkg::*;

  localparam int MAXP     = 16;
  localparam int SETTLE   = 300;
  localparam int LIMIT    = 3000000;
  localparam int HOLD_LEN = 3000;
  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [1:0] req;
    logic [7:0] ch;
    logic       eot;
  } char_req_t;

  typedef struct {
    logic        kind;
    logic [31:0] pos;
    logic [31:0] spur;
    logic        last;
  } match_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  rolling_hash_string_matcher_unit u_top (.*);

  always #6 clk = ~clk;

  char_req_t  pending_q[$];
  match_rec_t hits_q[$];
  char_req_t  cur_req;
  int         sent_cnt = 0;
  int         acc_cnt = 0;
  int         errors = 0;
  bit         no_idle = 1'b0;
  bit         hold_go = 1'b0;

  // shadow of the matcher
  logic [9:0]       sh_radix;
  logic [30:0]      sh_mod;
  logic [4:0]       sh_len;
  logic [7:0]       sh_pat[MAXP];
  logic [7:0]       sh_win[MAXP];
  longint unsigned  sh_pat_h, sh_win_h, sh_lead, sh_seen, sh_false;
  int               sh_loaded;

  function automatic longint unsigned char_val(logic [7:0] c, longint unsigned q);
    longint unsigned v;
    if (c >= "A" && c <= "Z") v = c - "A" + 10;
    else if (c >= "a" && c <= "z") v = c - "a" + 36;
    else if (c >= "0" && c <= "9") v = c - "0";
    else return q - 1;
    return v % q;
  endfunction

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b,
                                           longint unsigned q);
    return ((a % q) * (b % q)) % q;
  endfunction

  function automatic longint unsigned addq(longint unsigned a, longint unsigned b,
                                           longint unsigned q);
    longint unsigned s;
    s = a + b;
    if (s >= q) s -= q;
    return s;
  endfunction

  task automatic clear_text();
    foreach (sh_win[i]) sh_win[i] = '0;
    sh_win_h = 0;
    sh_seen  = 0;
    sh_false = 0;
  endtask

  task automatic shadow_reset();
    sh_radix = 10'd62;
    sh_mod   = 31'd101;
    sh_len   = 5'd1;
    foreach (sh_pat[i]) sh_pat[i] = '0;
    clear_text();
    sh_pat_h  = 0;
    sh_lead   = 1;
    sh_loaded = 0;
  endtask

  task automatic predict_matches(char_req_t r);
    longint unsigned q, v, t, drop;
    int m;
    bit same;
    match_rec_t e;
    int n;
    q = (sh_mod == 0) ? 1 : sh_mod;
    m = sh_len;
    n = 0;
    if (m < 1) m = 1;
    if (m > MAXP) m = MAXP;
    case (r.req)
      REQ_CLEAR: begin
        clear_text();
        sh_pat_h  = 0;
        sh_lead   = 1;
        sh_loaded = 0;
      end
      REQ_PAT: begin
        if (sh_loaded < m) begin
          v = char_val(r.ch, q);
          sh_pat[sh_loaded] = r.ch;
          sh_pat_h = addq(mulq(sh_pat_h, sh_radix, q), v, q);
          if (sh_loaded > 0) sh_lead = mulq(sh_lead, sh_radix, q);
          sh_loaded++;
        end
      end
      REQ_TEXT: begin
        v = char_val(r.ch, q);
        t = sh_win_h % q;
        if (sh_seen >= m) begin
          drop = mulq(char_val(sh_win[MAXP-m], q), sh_lead, q);
          t = addq(t, (drop == 0) ? 0 : q - drop, q);
        end
        sh_win_h = addq(mulq(t, sh_radix, q), v, q);
        for (int i = 0; i < MAXP-1; i++) sh_win[i] = sh_win[i+1];
        sh_win[MAXP-1] = r.ch;
        if (sh_seen < CNT_MAX) sh_seen++;
        if (sh_seen >= m && sh_loaded == m && (sh_pat_h % q) == sh_win_h) begin
          same = 1'b1;
          for (int i = 0; i < m; i++)
            if (sh_pat[i] != sh_win[MAXP-m+i]) same = 1'b0;
          if (same) begin
            e.kind = KIND_MATCH;
            e.pos  = 32'(sh_seen - m);
            e.spur = '0;
            e.last = 1'b0;
            hits_q = {hits_q, e};
            n++;
          end else if (sh_false < CNT_MAX) begin
            sh_false++;
          end
        end
        if (r.eot) begin
          e.kind = KIND_SUM;
          e.pos  = '0;
          e.spur = 32'(sh_false);
          e.last = 1'b0;
          hits_q = {hits_q, e};
          n++;
          clear_text();
        end
        if (n > 0) hits_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // accepted transactions on the input and config channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_matches(cur_req);
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIX:  sh_radix = cfg_data[9:0];
        CFG_MOD:    sh_mod   = cfg_data;
        CFG_PATLEN: sh_len   = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || sent_cnt == acc_cnt)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (in_tvalid && !no_idle && $urandom_range(0, 4) == 0) begin
        in_gap = $urandom_range(1, 16) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        in_tuser  <= cur_req.req;
        in_tdata  <= cur_req.ch;
        in_tlast  <= cur_req.eot;
        in_tvalid <= 1'b1;
        sent_cnt  = sent_cnt + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  int out_stall = 0;
  int out_hold = 0;
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      out_hold = HOLD_LEN;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(1, 16) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    match_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (hits_q.size() == 0) begin
        $error("unexpected result kind=%0d data=%h", out_tuser, out_tdata);
        errors++;
      end else begin
        e = hits_q.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_tuser); errors++;
        end
        if (out_tdata[31:0] !== e.pos) begin
          $error("match_pos exp %0d got %0d", e.pos, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== e.spur) begin
          $error("spurious_count exp %0d got %0d", e.spur, out_tdata[63:32]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_in_run exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] req, logic [7:0] ch, logic eot);
    char_req_t r;
    r.req = req;
    r.ch  = ch;
    r.eot = eot;
    pending_q = {pending_q, r};
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || sent_cnt != acc_cnt || hits_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(logic [7:0] pat[MAXP], int n);
    string abc;
    abc = "ab0Z";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1, 2: return abc[$urandom_range(0, 3)];
      default: return pat[$urandom_range(0, n-1)];
    endcase
  endfunction

  task automatic run_phase(logic [9:0] rdx, logic [30:0] q, logic [4:0] len, int n_items);
    logic [7:0] pat[MAXP];
    int m, r;
    string abc;
    abc = "ab0Z";
    wait_idle();
    write_reg(CFG_RADIX, 31'(rdx));
    write_reg(CFG_MOD, q);
    write_reg(CFG_PATLEN, 31'(len));
    m = (len == 0) ? 1 : (len > MAXP) ? MAXP : len;
    push_req(REQ_CLEAR, 8'($urandom), 1'($urandom));
    for (int i = 0; i < m; i++) begin
      pat[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : abc[$urandom_range(0, 3)];
      push_req(REQ_PAT, pat[i], 1'b0);
    end
    push_req(REQ_PAT, 8'($urandom), 1'b0);  // pattern full, ignored
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        for (int i = 0; i < m; i++) push_req(REQ_TEXT, pat[i], 1'b0);
        k += m - 1;
      end else if (r < 94) begin
        push_req(REQ_TEXT, pick_char(pat, m), $urandom_range(0, 59) == 0);
      end else if (r < 97) begin
        push_req(REQ_RSVD, 8'($urandom), 1'($urandom));
      end else if (r < 99) begin
        push_req(REQ_PAT, 8'($urandom), 1'($urandom));
      end else begin
        push_req(REQ_TEXT, 8'($urandom), 1'b1);
      end
    end
    push_req(REQ_TEXT, pick_char(pat, m), 1'b1);
  endtask

  initial begin
    string cls;
    logic [7:0] bnd [6];
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: text before the pattern exists, then the character classes
    push_req(REQ_TEXT, "a", 1'b0);
    push_req(REQ_TEXT, "b", 1'b1);
    push_req(REQ_PAT, "a", 1'b1);
    cls = "09AZaz";
    foreach (cls[i]) push_req(REQ_TEXT, cls[i], 1'b0);
    push_req(REQ_TEXT, 8'h00, 1'b0);
    push_req(REQ_TEXT, 8'hFF, 1'b0);
    // bytes just outside each character range
    bnd = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B};
    foreach (bnd[i]) push_req(REQ_TEXT, bnd[i], 1'b0);
    push_req(REQ_TEXT, "a", 1'b0);
    push_req(REQ_RSVD, 8'hFF, 1'b1);
    push_req(REQ_TEXT, "a", 1'b1);
    push_req(REQ_CLEAR, 8'h00, 1'b0);

    run_phase(10'd62, 31'd101, 5'd3, 200);
    hold_go = 1'b1;  // long receiver stall while input keeps coming
    run_phase(10'd1, 31'd2, 5'd1, 200);
    run_phase(10'd1023, 31'h7FFF_FFFF, 5'd16, 200);
    run_phase(10'd2, 31'd7, 5'd4, 200);
    run_phase(10'd10, 31'd0, 5'd2, 150);
    run_phase(10'd31, 31'd1, 5'd5, 150);
    run_phase(10'($urandom_range(1, 1023)), 31'($urandom_range(2, 5000)), 5'd0, 150);
    run_phase(10'($urandom_range(1, 1023)), 31'($urandom), 5'd20, 150);
    wait_idle();
    no_idle = 1'b1;
    run_phase(10'd62, 31'd13, 5'd2, 150);
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
